FILE: sv/jsu_pkg.sv
// jsu_pkg: types and constants shared by the json string unescaper modules
// holds the queue entry type, result kinds, error codes and input command flags
// no dependencies
package jsu_pkg;

   // result kinds as seen on rsp_tuser
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // error codes
   localparam logic [3:0] ERR_END_BEFORE_STR = 4'd0;
   localparam logic [3:0] ERR_EXPECT_QUOTE   = 4'd1;
   localparam logic [3:0] ERR_UNTERM_ESC     = 4'd2;
   localparam logic [3:0] ERR_UNTERM_STR     = 4'd3;
   localparam logic [3:0] ERR_TRUNC_HEX      = 4'd4;
   localparam logic [3:0] ERR_BAD_HEX        = 4'd5;
   localparam logic [3:0] ERR_LONE_HIGH      = 4'd6;
   localparam logic [3:0] ERR_BAD_PAIR       = 4'd7;
   localparam logic [3:0] ERR_LONE_LOW       = 4'd8;

   // input command flag on req_tuser
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // one queued job: a raw result or a code point to expand into utf-8
   typedef struct packed {
      logic        is_code;
      logic [1:0]  kind;
      logic [20:0] code;
      logic [3:0]  err;
   } job_type;

endpackage

FILE: sv/jsu_front.sv
// jsu_front: accepts input beats and runs the string/escape/hex parser
// emits one queue job per beat that causes results
// depends on jsu_pkg
module jsu_front
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        cmd,
   input  logic [7:0]  text_byte,
   input  logic        queue_full,
   output logic        job_valid,
   output job_type     job
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_STR     = 7'b0000010,
      ST_ESC     = 7'b0000100,
      ST_HEX1    = 7'b0001000,
      ST_WANT_BS = 7'b0010000,
      ST_WANT_U  = 7'b0100000,
      ST_HEX2    = 7'b1000000
   } mode_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [5:0] SURR_HIGH = 6'b110110;
   localparam logic [5:0] SURR_LOW  = 6'b110111;
   localparam logic [20:0] SUPP_BASE = 21'h10000;

   mode_type     mode_ff, mode_in;
   logic [1:0]   hex_count_ff, hex_count_in;
   logic [15:0]  code_accum_ff, code_accum_in;
   logic [9:0]   high_half_ff, high_half_in;

   logic         accept;
   logic         go_idle;
   logic         hex_ok;
   logic [3:0]   hex_val;
   logic [15:0]  acc_next;
   logic [20:0]  pair_code;

   function automatic job_type make_err(input logic [3:0] code);
      job_type j;
      j = '0;
      j.kind = KIND_ERROR;
      j.err  = code;
      return j;
   endfunction

   function automatic job_type make_byte(input logic [7:0] b);
      job_type j;
      j = '0;
      j.kind = KIND_BYTE;
      j.code = {13'd0, b};
      return j;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // hex digit decode, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (text_byte inside {[8'h30:8'h39]}) begin
         hex_val = text_byte[3:0];
      end else if (text_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         hex_val = 4'(text_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_next  = {code_accum_ff[11:0], hex_val};
   // 0x10000 + (high << 10) + low ten bits
   assign pair_code = SUPP_BASE + {1'b0, high_half_ff, acc_next[9:0]};

   // parser next state and job
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_accum_in = code_accum_ff;
      high_half_in  = high_half_ff;
      job_valid     = 1'b0;
      job           = '0;
      go_idle       = 1'b0;
      if (accept) begin
         if (cmd == CMD_END) begin
            job_valid = 1'b1;
            go_idle   = 1'b1;
            case (mode_ff)
               ST_IDLE:            job = make_err(ERR_END_BEFORE_STR);
               ST_STR:             job = make_err(ERR_UNTERM_STR);
               ST_ESC:             job = make_err(ERR_UNTERM_ESC);
               ST_HEX1, ST_HEX2:   job = make_err(ERR_TRUNC_HEX);
               default:            job = make_err(ERR_LONE_HIGH);
            endcase
         end else begin
            case (mode_ff)
               ST_IDLE: begin
                  if (text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                     mode_in = ST_IDLE;
                  end else if (text_byte == CH_QUOTE) begin
                     mode_in = ST_STR;
                  end else begin
                     job_valid = 1'b1;
                     job       = make_err(ERR_EXPECT_QUOTE);
                     go_idle   = 1'b1;
                  end
               end
               ST_STR: begin
                  job_valid = 1'b1;
                  if (text_byte == CH_QUOTE) begin
                     job      = '0;
                     job.kind = KIND_CLOSE;
                     go_idle  = 1'b1;
                  end else if (text_byte == CH_BSL) begin
                     job_valid = 1'b0;
                     mode_in   = ST_ESC;
                  end else begin
                     job = make_byte(text_byte);
                  end
               end
               ST_ESC: begin
                  mode_in   = ST_STR;
                  job_valid = 1'b1;
                  case (text_byte)
                     CH_N:    job = make_byte(CH_LF);
                     CH_T:    job = make_byte(CH_TAB);
                     CH_R:    job = make_byte(CH_CR);
                     CH_B:    job = make_byte(CH_BS);
                     CH_F:    job = make_byte(CH_FF);
                     CH_U: begin
                        job_valid     = 1'b0;
                        mode_in       = ST_HEX1;
                        hex_count_in  = 2'd0;
                        code_accum_in = 16'd0;
                     end
                     default: job = make_byte(text_byte);
                  endcase
               end
               ST_HEX1, ST_HEX2: begin
                  if (!hex_ok) begin
                     job_valid = 1'b1;
                     job       = make_err(ERR_BAD_HEX);
                     go_idle   = 1'b1;
                  end else if (hex_count_ff != 2'd3) begin
                     code_accum_in = acc_next;
                     hex_count_in  = hex_count_ff + 2'd1;
                  end else begin
                     hex_count_in  = 2'd0;
                     code_accum_in = 16'd0;
                     if (mode_ff == ST_HEX1) begin
                        if (acc_next[15:10] == SURR_HIGH) begin
                           high_half_in = acc_next[9:0];
                           mode_in      = ST_WANT_BS;
                        end else if (acc_next[15:10] == SURR_LOW) begin
                           job_valid = 1'b1;
                           job       = make_err(ERR_LONE_LOW);
                           go_idle   = 1'b1;
                        end else begin
                           job_valid   = 1'b1;
                           job         = '0;
                           job.is_code = 1'b1;
                           job.kind    = KIND_BYTE;
                           job.code    = {5'd0, acc_next};
                           mode_in     = ST_STR;
                        end
                     end else begin
                        job_valid = 1'b1;
                        if (acc_next[15:10] != SURR_LOW) begin
                           job     = make_err(ERR_BAD_PAIR);
                           go_idle = 1'b1;
                        end else begin
                           job          = '0;
                           job.is_code  = 1'b1;
                           job.kind     = KIND_BYTE;
                           job.code     = pair_code;
                           high_half_in = 10'd0;
                           mode_in      = ST_STR;
                        end
                     end
                  end
               end
               ST_WANT_BS: begin
                  if (text_byte == CH_BSL) begin
                     mode_in = ST_WANT_U;
                  end else begin
                     job_valid = 1'b1;
                     job       = make_err(ERR_LONE_HIGH);
                     go_idle   = 1'b1;
                  end
               end
               ST_WANT_U: begin
                  if (text_byte == CH_U) begin
                     mode_in       = ST_HEX2;
                     hex_count_in  = 2'd0;
                     code_accum_in = 16'd0;
                  end else begin
                     job_valid = 1'b1;
                     job       = make_err(ERR_LONE_HIGH);
                     go_idle   = 1'b1;
                  end
               end
               default: begin
                  go_idle = 1'b1;
               end
            endcase
         end
         if (go_idle) begin
            mode_in       = ST_IDLE;
            hex_count_in  = 2'd0;
            code_accum_in = 16'd0;
            high_half_in  = 10'd0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= ST_IDLE;
         hex_count_ff  <= 2'd0;
         code_accum_ff <= 16'd0;
         high_half_ff  <= 10'd0;
      end else begin
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_accum_ff <= code_accum_in;
         high_half_ff  <= high_half_in;
      end
   end

endmodule

FILE: sv/jsu_queue.sv
// jsu_queue: small job queue between parser front and utf-8 back end
// register array with read and write pointers and an occupancy count
// depends on jsu_pkg
module jsu_queue
   import jsu_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  job_type wr_data,
   output logic    full,
   output logic    rd_valid,
   output job_type rd_data,
   input  logic    rd_pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == FULL_CNT);
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && !full;
   assign do_rd    = rd_pop && rd_valid;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/jsu_back.sv
// jsu_back: expands queued jobs into result beats, one beat per cycle while rsp_ is not stalled
// utf-8 encoding of code points and the registered result stage
// depends on jsu_pkg
module jsu_back
   import jsu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic [1:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic [3:0]  err_ff, err_in;
   logic [1:0]  kind_ff, kind_in;
   logic        last_ff, last_in;

   logic        out_free;
   logic [1:0]  beats_m1;
   logic [7:0]  enc_byte;
   logic        is_last;
   logic [20:0] c;

   assign out_free = !valid_ff || rsp_tready;
   assign c        = job.code;

   // utf-8 length and byte at the current index
   always_comb begin
      beats_m1 = 2'd0;
      enc_byte = 8'd0;
      if (!job.is_code) begin
         beats_m1 = 2'd0;
         enc_byte = (job.kind == KIND_BYTE) ? c[7:0] : 8'd0;
      end else if (c < 21'h80) begin
         beats_m1 = 2'd0;
         enc_byte = c[7:0];
      end else if (c < 21'h800) begin
         beats_m1 = 2'd1;
         case (idx_ff)
            2'd0:    enc_byte = {3'b110, c[10:6]};
            default: enc_byte = {2'b10, c[5:0]};
         endcase
      end else if (c < 21'h10000) begin
         beats_m1 = 2'd2;
         case (idx_ff)
            2'd0:    enc_byte = {4'b1110, c[15:12]};
            2'd1:    enc_byte = {2'b10, c[11:6]};
            default: enc_byte = {2'b10, c[5:0]};
         endcase
      end else begin
         beats_m1 = 2'd3;
         case (idx_ff)
            2'd0:    enc_byte = {5'b11110, c[20:18]};
            2'd1:    enc_byte = {2'b10, c[17:12]};
            2'd2:    enc_byte = {2'b10, c[11:6]};
            default: enc_byte = {2'b10, c[5:0]};
         endcase
      end
   end

   assign is_last = (idx_ff == beats_m1);
   assign job_pop = job_valid && out_free && is_last;

   // output stage and beat index
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      err_in   = err_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = job_valid;
         if (job_valid) begin
            byte_in = enc_byte;
            err_in  = job.err;
            kind_in = job.kind;
            last_in = is_last;
            idx_in  = is_last ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      err_ff  <= err_in;
      kind_ff <= kind_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, err_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

FILE: sv/json_string_unescape_utf8_core.sv
// json_string_unescape_utf8_core: streaming json string unescaper, top level
// parser front, job queue and utf-8 back end
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back
//
//   channel  dir  tdata                                tuser         tlast
//   req_     in   [7:0] text_byte                      command       -
//   rsp_     out  [7:0] out_byte, [11:8] error_code    out_kind      last_of_run
//
// one input beat is taken per cycle while the job queue has room
// the back end sends one result beat per cycle while rsp_ is not stalled;
// a \u code point takes 1 to 4 beats, and jobs pass queue and output register
// reset is synchronous and clears parser state, queue and output valid
// a stalled rsp_ side fills the queue, after which req_tready drops
module json_string_unescape_utf8_core
   import jsu_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [11:8] error_code, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] out_kind
   output logic        rsp_tlast
);

   logic    front_job_valid;
   job_type front_job;
   logic    queue_full;
   logic    head_valid;
   job_type head_job;
   logic    head_pop;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (req_tuser),
      .text_byte  (req_tdata),
      .queue_full (queue_full),
      .job_valid  (front_job_valid),
      .job        (front_job)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_job_valid),
      .wr_data  (front_job),
      .full     (queue_full),
      .rd_valid (head_valid),
      .rd_data  (head_job),
      .rd_pop   (head_pop)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (head_valid),
      .job        (head_job),
      .job_pop    (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: sv/jsu_checker.sv
// jsu_checker: port level checks on the unescaper result channel
// bound to json_string_unescape_utf8_core
// depends on jsu_pkg
module jsu_checker
   import jsu_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled beat stays valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   // a stalled beat keeps its payload
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // close and error results always end their run
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_CLOSE || rsp_tuser == KIND_ERROR) |-> rsp_tlast)
      else $error("close or error not last of run");

   // error code only with errors, byte only with bytes, no unknown kind, padding zero
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3 && rsp_tdata[15:12] == 4'd0 &&
         (rsp_tuser == KIND_ERROR || rsp_tdata[11:8] == 4'd0) &&
         (rsp_tuser == KIND_BYTE || rsp_tdata[7:0] == 8'd0))
      else $error("inconsistent rsp fields");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
